@@ sv/pdrt_pkg.sv @@
`default_nettype none

package pdrt_pkg;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned OFF_W  = 5;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned PAGE_W = 6;

    localparam logic [PAGE_W-1:0] PAGE_RST = 6'd32;

    typedef enum logic [FUNC_W-1:0] {
        FN_MARK  = 2'd0,
        FN_CLEAR = 2'd1,
        FN_TAKE  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_TAKE,
        ST_GAP,
        ST_DONE
    } t_state;

    // control into the bit step unit
    typedef struct packed {
        logic set_en;
        logic clr_en;
    } t_unit_ctl;

    // flags back from the bit step unit
    typedef struct packed {
        logic hit;
        logic fresh;
        logic mask_zero;
    } t_unit_res;

endpackage

`default_nettype wire

@@ sv/pdrt_if.sv @@
`default_nettype none

interface pdrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [4:0] mark_offset;
    logic [5:0] run_length;

    modport source (output valid, output func, output mark_offset, output run_length,
                    input ready);
    modport sink (input valid, input func, input mark_offset, input run_length,
                  output ready);
endinterface

interface pdrt_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] run_start;
    logic [5:0] run_blocks;
    logic [5:0] dirty_left;

    modport source (output valid, output run_start, output run_blocks, output dirty_left,
                    input ready);
    modport sink (input valid, input run_start, input run_blocks, input dirty_left,
                  output ready);
endinterface

`default_nettype wire

@@ sv/pdrt_bit_unit.sv @@
`default_nettype none

module pdrt_bit_unit #(
    parameter int unsigned MAX_BLOCKS = 32
) (
    input  wire logic [MAX_BLOCKS-1:0] i_map,
    input  wire logic [MAX_BLOCKS-1:0] i_mask,
    input  wire pdrt_pkg::t_unit_ctl   i_ctl,
    output      logic [MAX_BLOCKS-1:0] o_map,
    output      logic [MAX_BLOCKS-1:0] o_mask,
    output      pdrt_pkg::t_unit_res   o_res
);

    always_comb begin
        o_res.hit       = |(i_map & i_mask);
        o_res.fresh     = |(i_mask & ~i_map);
        o_res.mask_zero = ~|i_mask;
        if (i_ctl.set_en) begin
            o_map = i_map | i_mask;
        end else if (i_ctl.clr_en) begin
            o_map = i_map & ~i_mask;
        end else begin
            o_map = i_map;
        end
        // walking one-hot; it falls off past the top of the map
        o_mask = i_mask << 1;
    end

endmodule

`default_nettype wire

@@ sv/page_dirty_run_tracker_unit.sv @@
// Dirty block tracker for one page buffer of up to MAX_BLOCKS blocks. Each request
// (mark run, clear all, take next run, or the unused code which does nothing) gives
// exactly one response carrying the returned run start, the run length and the dirty
// count left. A one-bit step unit walks the bitmap one block per cycle, and the
// block takes one request at a time: a mark walks its run, a take that walks steps
// over the run and the clean gap after it; any request may wait for the previous
// response to be taken. The user must write page_blocks through the configuration
// port only while the block is idle (the block does not enforce it); it resets to 32.
`default_nettype none

module page_dirty_run_tracker_unit #(
    parameter int unsigned MAX_BLOCKS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [pdrt_pkg::PAGE_W-1:0]  i_cfg_wdata,
    pdrt_req_if.sink                          i_req,
    pdrt_rsp_if.source                        o_rsp
);

    localparam int unsigned TAKEN_W = pdrt_pkg::CNT_W + 1;
    localparam int unsigned SUM_W   = pdrt_pkg::CNT_W + 1;

    pdrt_pkg::t_state r_state, n_state;

    logic [MAX_BLOCKS-1:0]          r_map, n_map;
    logic [MAX_BLOCKS-1:0]          r_mask, n_mask;
    logic [pdrt_pkg::CNT_W-1:0]     r_total, n_total;
    logic [pdrt_pkg::OFF_W-1:0]     r_first, n_first;
    logic [pdrt_pkg::PAGE_W-1:0]    r_page;
    logic [pdrt_pkg::LEN_W-1:0]     r_cnt, n_cnt;
    logic [TAKEN_W-1:0]             r_taken, n_taken;
    logic [pdrt_pkg::OFF_W-1:0]     r_pos, n_pos;
    logic                           r_gap, n_gap;
    logic [pdrt_pkg::OFF_W-1:0]     r_res_start, n_res_start;
    logic [pdrt_pkg::CNT_W-1:0]     r_res_blocks, n_res_blocks;

    logic                           r_out_valid, n_out_valid;
    logic [pdrt_pkg::OFF_W-1:0]     r_out_start, n_out_start;
    logic [pdrt_pkg::CNT_W-1:0]     r_out_blocks, n_out_blocks;
    logic [pdrt_pkg::CNT_W-1:0]     r_out_left, n_out_left;

    logic [pdrt_pkg::OFF_W-1:0]     w_dec_src;
    logic [MAX_BLOCKS-1:0]          w_dec;
    logic [SUM_W-1:0]               w_tail_sum;
    logic                           w_accept;
    pdrt_pkg::t_unit_ctl            w_ctl;
    pdrt_pkg::t_unit_res            w_res;
    logic [MAX_BLOCKS-1:0]          w_unit_map;
    logic [MAX_BLOCKS-1:0]          w_unit_mask;

    assign w_accept = i_req.valid && i_req.ready;

    // one-hot of the start block; empty when it lies past the top of the map
    assign w_dec_src = (pdrt_pkg::t_func'(i_req.func) == pdrt_pkg::FN_MARK)
                       ? i_req.mark_offset : r_first;
    always_comb begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            w_dec[k] = (7'(k) == {2'b00, w_dec_src});
        end
    end

    assign w_tail_sum = {2'b00, r_first} + {1'b0, r_total};

    pdrt_bit_unit #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_bit_unit (
        .i_map  (r_map),
        .i_mask (r_mask),
        .i_ctl  (w_ctl),
        .o_map  (w_unit_map),
        .o_mask (w_unit_mask),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdrt_pkg::ST_IDLE;
            r_map       <= '0;
            r_total     <= '0;
            r_first     <= '0;
            r_page      <= pdrt_pkg::PAGE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_total     <= n_total;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_page <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask       <= n_mask;
        r_cnt        <= n_cnt;
        r_taken      <= n_taken;
        r_pos        <= n_pos;
        r_gap        <= n_gap;
        r_res_start  <= n_res_start;
        r_res_blocks <= n_res_blocks;
        r_out_start  <= n_out_start;
        r_out_blocks <= n_out_blocks;
        r_out_left   <= n_out_left;
    end

    always_comb begin
        n_state      = r_state;
        n_map        = r_map;
        n_mask       = r_mask;
        n_total      = r_total;
        n_first      = r_first;
        n_cnt        = r_cnt;
        n_taken      = r_taken;
        n_pos        = r_pos;
        n_gap        = r_gap;
        n_res_start  = r_res_start;
        n_res_blocks = r_res_blocks;
        n_out_valid  = r_out_valid;
        n_out_start  = r_out_start;
        n_out_blocks = r_out_blocks;
        n_out_left   = r_out_left;
        w_ctl        = '0;
        i_req.ready  = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pdrt_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (w_accept) begin
                    n_res_start  = '0;
                    n_res_blocks = '0;
                    n_state      = pdrt_pkg::ST_DONE;
                    case (pdrt_pkg::t_func'(i_req.func))
                        pdrt_pkg::FN_MARK: begin
                            if (r_map == '0 || i_req.mark_offset < r_first) begin
                                n_first = i_req.mark_offset;
                            end
                            n_mask = w_dec;
                            n_cnt  = i_req.run_length;
                            if (i_req.run_length != '0) begin
                                n_state = pdrt_pkg::ST_MARK;
                            end
                        end
                        pdrt_pkg::FN_CLEAR: begin
                            n_map   = '0;
                            n_total = '0;
                            n_first = '0;
                        end
                        pdrt_pkg::FN_TAKE: begin
                            if (r_total == '0) begin
                                n_state = pdrt_pkg::ST_DONE;
                            end else if (r_total == pdrt_pkg::CNT_W'(1)) begin
                                n_res_start  = r_first;
                                n_res_blocks = pdrt_pkg::CNT_W'(1);
                                n_map        = '0;
                                n_total      = '0;
                                n_first      = '0;
                            end else if (w_tail_sum == {1'b0, r_page}) begin
                                // dirty all the way to the end of the page
                                n_res_start  = r_first;
                                n_res_blocks = r_total;
                                n_map        = '0;
                                n_total      = '0;
                                n_first      = '0;
                            end else if (!(|(r_map & w_dec))) begin
                                n_map   = '0;
                                n_total = '0;
                                n_first = '0;
                            end else begin
                                n_mask  = w_dec;
                                n_taken = '0;
                                n_pos   = r_first;
                                n_gap   = 1'b0;
                                n_state = pdrt_pkg::ST_TAKE;
                            end
                        end
                        default: begin
                            n_state = pdrt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pdrt_pkg::ST_MARK: begin
                w_ctl.set_en = 1'b1;
                n_map  = w_unit_map;
                n_mask = w_unit_mask;
                if (w_res.fresh) begin
                    n_total = r_total + pdrt_pkg::CNT_W'(1);
                end
                n_cnt = r_cnt - pdrt_pkg::LEN_W'(1);
                if (r_cnt == pdrt_pkg::LEN_W'(1)) begin
                    n_state = pdrt_pkg::ST_DONE;
                end
            end
            pdrt_pkg::ST_TAKE: begin
                if (w_res.hit) begin
                    w_ctl.clr_en = 1'b1;
                    n_map   = w_unit_map;
                    n_mask  = w_unit_mask;
                    n_taken = r_taken + TAKEN_W'(1);
                    n_pos   = r_pos + pdrt_pkg::OFF_W'(1);
                end else begin
                    n_state = pdrt_pkg::ST_GAP;
                end
            end
            pdrt_pkg::ST_GAP: begin
                if (!w_res.mask_zero && !w_res.hit) begin
                    n_mask = w_unit_mask;
                    n_gap  = 1'b1;
                    n_pos  = r_pos + pdrt_pkg::OFF_W'(1);
                end else begin
                    n_res_start  = r_first;
                    n_res_blocks = r_taken[pdrt_pkg::CNT_W-1:0];
                    if (r_gap) begin
                        n_first = r_pos;
                        n_total = r_total - r_taken[pdrt_pkg::CNT_W-1:0];
                    end else begin
                        // run reached the top with no clean gap after it
                        n_map   = '0;
                        n_total = '0;
                        n_first = '0;
                    end
                    n_state = pdrt_pkg::ST_DONE;
                end
            end
            pdrt_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_start  = r_res_start;
                    n_out_blocks = r_res_blocks;
                    n_out_left   = r_total;
                    n_state      = pdrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdrt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.run_start  = r_out_start;
    assign o_rsp.run_blocks = r_out_blocks;
    assign o_rsp.dirty_left = r_out_left;

endmodule

`default_nettype wire

@@ sv/pdrt_checker.sv @@
`default_nettype none

module pdrt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_req_valid,
    input wire logic       i_req_ready,
    input wire logic       i_rsp_valid,
    input wire logic       i_rsp_ready,
    input wire logic [4:0] i_run_start,
    input wire logic [5:0] i_run_blocks,
    input wire logic [5:0] i_dirty_left
);

    // a response waiting to be taken stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped before transfer");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable({i_run_start, i_run_blocks, i_dirty_left}))
        else $error("response payload changed before transfer");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid straight after reset");

    // no new request is taken in the cycle after one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one still in work");

    a_empty_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_run_blocks == 6'd0 |-> i_run_start == 5'd0)
        else $error("empty run with nonzero start");

endmodule

bind page_dirty_run_tracker_unit pdrt_checker u_pdrt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_run_start  (o_rsp.run_start),
    .i_run_blocks (o_rsp.run_blocks),
    .i_dirty_left (o_rsp.dirty_left)
);

`default_nettype wire
